// ===== hw/rtl/aat_pkg.sv =====
package aat_pkg;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_BKT_RD,
        OP_BKT_LATCH,
        OP_ENT_RD,
        OP_ADD_POP,
        OP_ADD_LINK,
        OP_STALE_A,
        OP_STALE_B,
        OP_ADVANCE,
        OP_MATCH_A,
        OP_MATCH_B,
        OP_MATCH_C,
        OP_REFRESH,
        OP_BKT_WR,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   ok;
    } dp_cmd_t;

    typedef struct packed {
        logic clearing;
        logic hash_done;
        logic is_find;
        logic fh_valid;
        logic e_valid;
        logic steps_ok;
        logic stale;
        logic match;
        logic nx_valid;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hw/rtl/aat_in_if.sv =====
interface aat_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] address;
    logic [31:0] current_time;

    modport source (output valid, output mode, output address, output current_time,
                    input ready);
    modport sink   (input valid, input mode, input address, input current_time,
                    output ready);
endinterface

// ===== hw/rtl/aat_out_if.sv =====
interface aat_out_if;
    logic        valid;
    logic        ready;
    logic        success;
    logic [10:0] entries_used;

    modport source (output valid, output success, output entries_used, input ready);
    modport sink   (input valid, input success, input entries_used, output ready);
endinterface

// ===== hw/rtl/aging_address_table.sv =====
// Channel   Dir  Beat fields
// in_ch     in   mode, address, current_time
// out_ch    out  success, entries_used
// cfg       in   cfg_write, cfg_data (expiry_interval)
//
// One item at a time. Every item passes a load step, the bucket hash
// (4 byte rounds, 1 mix, 1 reciprocal multiply, 1 remainder, a done check),
// the bucket memory read and latch, then:
//   add:  free-list link read, pop, append, bucket write-back, then the result
//         step; a failed add skips these 4;
//   find: a read and an advance per live entry passed; a read, an unlink and
//         a free per stale entry; a move to the tail (not when already there)
//         and a refresh for a match; then the bucket write-back.
// The result step hands the beat to the output register; it stalls while the
// previous beat is still held. The next input beat can be taken while a result
// waits. After reset, a clearing pass over every bucket address empties every
// bucket; input ready stays low until it ends.
module aging_address_table #(
    parameter int POOL_ENTRIES = 1024,
    parameter int BUCKET_COUNT = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    aat_in_if.sink      in_ch,
    aat_out_if.source   out_ch,
    input  logic        cfg_write,
    input  logic [31:0] cfg_data
);
    import aat_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_ready;

    // Controller: sequences the hash, bucket read, chain walk and write-back.
    aat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: entry pool, bucket memory, free list, counters and result beat.
    aat_datapath #(
        .POOL_ENTRIES (POOL_ENTRIES),
        .BUCKET_COUNT (BUCKET_COUNT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_mode    (in_ch.mode),
        .in_address (in_ch.address),
        .in_time    (in_ch.current_time),
        .in_beat    (in_ch.valid && in_ready),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .out_ch     (out_ch)
    );

    assign in_ch.ready = in_ready;
endmodule

// ===== hw/rtl/aat_hash.sv =====
module aat_hash #(
    parameter int BUCKET_COUNT = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] address,
    output logic        done,
    output logic [(BUCKET_COUNT > 1 ? $clog2(BUCKET_COUNT) : 1)-1:0] bucket
);
    localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int SH = $clog2(BUCKET_COUNT);
    // ceil(2^(32+SH) / BUCKET_COUNT) gives the exact quotient for any 32-bit hash
    localparam logic [63:0] RECIP = ((64'd1 << (32 + SH)) + 64'(BUCKET_COUNT) - 64'd1)
                                    / 64'(BUCKET_COUNT);
    localparam logic [31:0] RECIP_LO = RECIP[31:0];
    localparam logic        RECIP_HI = RECIP[32];
    localparam logic [31:0] DIVISOR  = 32'(BUCKET_COUNT);
    localparam logic [3:0] LAST_ROUND = 4'd3;
    localparam logic [3:0] MIX_STEP   = 4'd4;
    localparam logic [3:0] QUOT_STEP  = 4'd5;

    logic [31:0]   h_reg, h_next;
    logic [31:0]   a_reg, a_next;
    logic [31:0]   q_reg, q_next;
    logic [BW-1:0] r_reg, r_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    always_comb
    begin
        logic [31:0] t;
        logic [64:0] p;
        logic [64:0] qf;
        logic [31:0] qm;
        logic [31:0] rem;
        t = h_reg;
        p = '0;
        qf = '0;
        qm = '0;
        rem = '0;
        h_next = h_reg;
        a_next = a_reg;
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            h_next = '0;
            a_next = address;
            r_next = '0;
            cnt_next = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg <= LAST_ROUND)
            begin
                // one byte round, low byte first
                t = h_reg + {24'd0, a_reg[7:0]};
                t = t + (t << 10);
                t = t ^ (t >> 6);
                h_next = t;
                a_next = a_reg >> 8;
            end
            else if (cnt_reg == MIX_STEP)
            begin
                t = h_reg + (h_reg << 3);
                t = t ^ (t >> 11);
                t = t + (t << 15);
                h_next = t;
            end
            else if (cnt_reg == QUOT_STEP)
            begin
                // quotient by reciprocal multiply
                p = {1'b0, {32'd0, h_reg} * {32'd0, RECIP_LO}};
                if (RECIP_HI)
                    p = p + {1'b0, h_reg, 32'd0};
                qf = p >> (32 + SH);
                q_next = qf[31:0];
            end
            else
            begin
                // remainder from the quotient
                qm = q_reg * DIVISOR;
                rem = h_reg - qm;
                r_next = rem[BW-1:0];
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
        a_reg <= a_next;
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign done   = done_reg;
    assign bucket = r_reg;
endmodule

// ===== hw/rtl/aat_datapath.sv =====
module aat_datapath #(
    parameter int POOL_ENTRIES = 1024,
    parameter int BUCKET_COUNT = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  aat_pkg::dp_cmd_t    cmd,
    output aat_pkg::dp_status_t status,
    input  logic                in_mode,
    input  logic [31:0]         in_address,
    input  logic [31:0]         in_time,
    input  logic                in_beat,
    input  logic                cfg_write,
    input  logic [31:0]         cfg_data,
    aat_out_if.source           out_ch
);
    import aat_pkg::*;

    localparam int AW = $clog2(POOL_ENTRIES);
    localparam int EW = $clog2(POOL_ENTRIES + 1);
    localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int CW = $clog2(BUCKET_COUNT + 1);
    localparam logic [EW-1:0] NIL = EW'(POOL_ENTRIES);
    localparam logic [CW-1:0] CLR_LAST = CW'(BUCKET_COUNT - 1);

    logic [EW-1:0]     link_mem [POOL_ENTRIES];
    logic [63:0]       data_mem [POOL_ENTRIES];
    logic [2*EW-1:0]   bkt_mem  [BUCKET_COUNT];

    logic [EW-1:0]     link_rd;
    logic [63:0]       data_rd;
    logic [2*EW-1:0]   bkt_rd;

    logic [31:0]       expiry_reg;
    logic              mode_reg;
    logic [31:0]       addr_reg, now_reg, age_reg;
    logic              can_exp_reg;
    logic [EW-1:0]     head_reg, head_next;
    logic [EW-1:0]     tail_reg, tail_next;
    logic [EW-1:0]     e_reg, e_next;
    logic [EW-1:0]     prev_reg, prev_next;
    logic [EW-1:0]     steps_reg, steps_next;
    logic [EW-1:0]     free_head_reg, free_head_next;
    logic [EW-1:0]     hwm_reg, hwm_next;
    logic [EW-1:0]     used_reg, used_next;
    logic [CW-1:0]     clr_reg;
    logic              clearing_reg;
    logic              out_valid_reg;
    logic              out_ok_reg;
    logic [10:0]       out_used_reg;

    logic              hash_done;
    logic [BW-1:0]     bucket;

    logic              link_we;
    logic [EW-1:0]     link_wa, link_wd;
    logic [EW-1:0]     nx;
    logic              nx_valid, prev_valid, tail_valid;

    aat_hash #(.BUCKET_COUNT(BUCKET_COUNT)) u_hash (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.op == OP_LOAD),
        .address (in_address),
        .done    (hash_done),
        .bucket  (bucket)
    );

    assign nx         = link_rd;
    assign nx_valid   = nx < NIL;
    assign prev_valid = prev_reg < NIL;
    assign tail_valid = tail_reg < NIL;

    always_comb
    begin
        status.clearing  = clearing_reg;
        status.hash_done = hash_done;
        status.is_find   = mode_reg;
        status.fh_valid  = free_head_reg < NIL;
        status.e_valid   = e_reg < NIL;
        status.steps_ok  = steps_reg < NIL;
        status.stale     = can_exp_reg && (data_rd[31:0] < age_reg);
        status.match     = data_rd[63:32] == addr_reg;
        status.nx_valid  = nx_valid;
        status.out_free  = !out_valid_reg || out_ch.ready;
    end

    // link memory write port
    always_comb
    begin
        link_we = 1'b0;
        link_wa = e_reg;
        link_wd = NIL;
        unique case (cmd.op)
            OP_ADD_POP, OP_MATCH_B:
                link_we = 1'b1;
            OP_ADD_LINK, OP_MATCH_C:
            begin
                link_we = tail_valid;
                link_wa = tail_reg;
                link_wd = e_reg;
            end
            OP_STALE_A, OP_MATCH_A:
            begin
                link_we = prev_valid;
                link_wa = prev_reg;
                link_wd = nx;
            end
            OP_STALE_B:
            begin
                link_we = 1'b1;
                link_wd = free_head_reg;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        e_next = e_reg;
        prev_next = prev_reg;
        steps_next = steps_reg;
        free_head_next = free_head_reg;
        hwm_next = hwm_reg;
        used_next = used_reg;
        unique case (cmd.op)
            OP_BKT_LATCH:
            begin
                head_next  = bkt_rd[2*EW-1:EW];
                tail_next  = bkt_rd[EW-1:0];
                e_next     = mode_reg ? bkt_rd[2*EW-1:EW] : free_head_reg;
                prev_next  = NIL;
                steps_next = '0;
            end
            OP_ADD_POP:
            begin
                // untouched part of the pool chains implicitly to the next entry
                if (free_head_reg == hwm_reg)
                begin
                    free_head_next = hwm_reg + EW'(1);
                    hwm_next = hwm_reg + EW'(1);
                end
                else
                    free_head_next = nx;
                used_next = used_reg + EW'(1);
            end
            OP_ADD_LINK:
            begin
                if (!tail_valid)
                    head_next = e_reg;
                tail_next = e_reg;
            end
            OP_STALE_A:
            begin
                if (!prev_valid)
                    head_next = nx;
                if (!nx_valid)
                    tail_next = prev_reg;
            end
            OP_STALE_B:
            begin
                free_head_next = e_reg;
                if (used_reg != '0)
                    used_next = used_reg - EW'(1);
                e_next = nx;
                steps_next = steps_reg + EW'(1);
            end
            OP_ADVANCE:
            begin
                prev_next = e_reg;
                e_next = nx;
                steps_next = steps_reg + EW'(1);
            end
            OP_MATCH_A:
            begin
                if (!prev_valid)
                    head_next = nx;
            end
            OP_MATCH_C:
                tail_next = e_reg;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expiry_reg    <= 32'd60;
            free_head_reg <= '0;
            hwm_reg       <= '0;
            used_reg      <= '0;
            clr_reg       <= '0;
            clearing_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                expiry_reg <= cfg_data;
            free_head_reg <= free_head_next;
            hwm_reg       <= hwm_next;
            used_reg      <= used_next;
            if (clearing_reg)
            begin
                clr_reg <= clr_reg + CW'(1);
                if (clr_reg == CLR_LAST)
                    clearing_reg <= 1'b0;
            end
            if (cmd.op == OP_RESULT)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            mode_reg    <= in_mode;
            addr_reg    <= in_address;
            now_reg     <= in_time;
            age_reg     <= in_time - expiry_reg;
            can_exp_reg <= expiry_reg <= in_time;
        end
        head_reg  <= head_next;
        tail_reg  <= tail_next;
        e_reg     <= e_next;
        prev_reg  <= prev_next;
        steps_reg <= steps_next;
        if (cmd.op == OP_RESULT)
        begin
            out_ok_reg   <= cmd.ok;
            out_used_reg <= 11'(used_reg);
        end
    end

    // entry memories
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_ENT_RD)
        begin
            link_rd <= link_mem[e_reg[AW-1:0]];
            data_rd <= data_mem[e_reg[AW-1:0]];
        end
        if (link_we)
            link_mem[link_wa[AW-1:0]] <= link_wd;
        if (cmd.op == OP_ADD_POP || cmd.op == OP_REFRESH)
            data_mem[e_reg[AW-1:0]] <= {addr_reg, now_reg};
    end

    // bucket head/tail memory
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_BKT_RD)
            bkt_rd <= bkt_mem[bucket];
        if (clearing_reg)
            bkt_mem[clr_reg[BW-1:0]] <= {NIL, NIL};
        else if (cmd.op == OP_BKT_WR)
            bkt_mem[bucket] <= {head_reg, tail_reg};
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.success      = out_ok_reg;
    assign out_ch.entries_used = out_used_reg;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= NIL)
        else $error("entry count above pool size");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_ADD_POP |-> free_head_reg < NIL)
        else $error("pop from empty free list");
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_RESULT |=> out_ch.valid)
        else $error("result beat not presented");
    a_no_beat_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |-> !clearing_reg)
        else $error("input beat during bucket clear");
`endif
endmodule

// ===== hw/rtl/aat_ctrl.sv =====
module aat_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  aat_pkg::dp_status_t status,
    output aat_pkg::dp_cmd_t    cmd
);
    import aat_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_HASH, S_BKT_RD, S_BKT_LATCH, S_ADD_RD, S_ADD_POP, S_ADD_LINK,
        S_WALK, S_EVAL, S_STALE_A, S_STALE_B, S_MATCH_A, S_MATCH_B, S_MATCH_C,
        S_REFRESH, S_BKT_WR, S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   ok_reg, ok_next;

    always_comb
    begin
        state_next = state_reg;
        ok_next = ok_reg;
        in_ready = 1'b0;
        cmd.op = OP_NONE;
        cmd.ok = ok_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = !status.clearing;
                if (in_valid && !status.clearing)
                begin
                    cmd.op = OP_LOAD;
                    state_next = S_HASH;
                end
            end
            S_HASH:
                if (status.hash_done)
                    state_next = S_BKT_RD;
            S_BKT_RD:
            begin
                cmd.op = OP_BKT_RD;
                state_next = S_BKT_LATCH;
            end
            S_BKT_LATCH:
            begin
                cmd.op = OP_BKT_LATCH;
                ok_next = 1'b0;
                if (status.is_find)
                    state_next = S_WALK;
                else if (status.fh_valid)
                    state_next = S_ADD_RD;
                else
                    state_next = S_RESULT;
            end
            S_ADD_RD:
            begin
                cmd.op = OP_ENT_RD;
                state_next = S_ADD_POP;
            end
            S_ADD_POP:
            begin
                cmd.op = OP_ADD_POP;
                state_next = S_ADD_LINK;
            end
            S_ADD_LINK:
            begin
                cmd.op = OP_ADD_LINK;
                ok_next = 1'b1;
                state_next = S_BKT_WR;
            end
            S_WALK:
                if (status.e_valid && status.steps_ok)
                begin
                    cmd.op = OP_ENT_RD;
                    state_next = S_EVAL;
                end
                else
                    state_next = S_BKT_WR;
            S_EVAL:
                if (status.stale)
                    state_next = S_STALE_A;
                else if (status.match)
                    state_next = status.nx_valid ? S_MATCH_A : S_REFRESH;
                else
                begin
                    cmd.op = OP_ADVANCE;
                    state_next = S_WALK;
                end
            S_STALE_A:
            begin
                cmd.op = OP_STALE_A;
                state_next = S_STALE_B;
            end
            S_STALE_B:
            begin
                cmd.op = OP_STALE_B;
                state_next = S_WALK;
            end
            S_MATCH_A:
            begin
                cmd.op = OP_MATCH_A;
                state_next = S_MATCH_B;
            end
            S_MATCH_B:
            begin
                cmd.op = OP_MATCH_B;
                state_next = S_MATCH_C;
            end
            S_MATCH_C:
            begin
                cmd.op = OP_MATCH_C;
                state_next = S_REFRESH;
            end
            S_REFRESH:
            begin
                cmd.op = OP_REFRESH;
                ok_next = 1'b1;
                state_next = S_BKT_WR;
            end
            S_BKT_WR:
            begin
                cmd.op = OP_BKT_WR;
                state_next = S_RESULT;
            end
            S_RESULT:
                if (status.out_free)
                begin
                    cmd.op = OP_RESULT;
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ok_reg    <= ok_next;
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE && !status.clearing)
        else $error("ready outside idle");
    a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EVAL |-> $past(cmd.op) == OP_ENT_RD)
        else $error("entry evaluated without a read");
    a_pop_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_ADD_POP |-> $past(cmd.op) == OP_ENT_RD)
        else $error("free list popped without link read");
`endif
endmodule

// ===== verif/aging_address_table_test.sv =====
module aging_address_table_test;

    localparam int POOL_ENTRIES = 1024;
    localparam int BUCKET_COUNT = 256;
    localparam int EMPTY_MARK   = POOL_ENTRIES;
    localparam bit MODE_ADD     = 1'b0;
    localparam bit MODE_FIND    = 1'b1;
    localparam int RANDOM_ITEMS = 800;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [31:0] cfg_data;

    aat_in_if  in_ch ();
    aat_out_if out_ch ();

    aging_address_table #(
        .POOL_ENTRIES(POOL_ENTRIES),
        .BUCKET_COUNT(BUCKET_COUNT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source),
        .cfg_write(cfg_write),
        .cfg_data(cfg_data)
    );

    typedef struct packed {
        logic        success;
        logic [10:0] entries_used;
    } lookup_reply_t;

    // Shadow copy of the table, kept in step with every accepted input beat.
    logic [31:0] shadow_interval;
    logic [31:0] shadow_addr  [POOL_ENTRIES];
    logic [31:0] shadow_stamp [POOL_ENTRIES];
    int          shadow_link  [POOL_ENTRIES];
    int          shadow_head  [BUCKET_COUNT];
    int          shadow_tail  [BUCKET_COUNT];
    int          shadow_free;
    int          shadow_used;

    lookup_reply_t pending_replies[$];
    bit            failed;

    // Pool of addresses already added, so finds mostly hit something.
    logic [31:0] known_addrs[$];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Bail out on a hang; sized for clearing pass, long walks and worst stalls.
    initial
    begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end

    // One-at-a-time hash over the address bytes, low byte first.
    function automatic int bucket_index(logic [31:0] addr);
        logic [31:0] h;
        h = '0;
        for (int i = 0; i < 4; i++)
        begin
            h = h + ((addr >> (8 * i)) & 32'hFF);
            h = h + (h << 10);
            h = h ^ (h >> 6);
        end
        h = h + (h << 3);
        h = h ^ (h >> 11);
        h = h + (h << 15);
        return int'(h % BUCKET_COUNT);
    endfunction

    function automatic void reset_shadow();
        shadow_interval = 32'd60;
        for (int i = 0; i < POOL_ENTRIES; i++)
            shadow_link[i] = i + 1;
        for (int i = 0; i < BUCKET_COUNT; i++)
        begin
            shadow_head[i] = EMPTY_MARK;
            shadow_tail[i] = EMPTY_MARK;
        end
        shadow_free = 0;
        shadow_used = 0;
    endfunction

    function automatic bit shadow_add(logic [31:0] addr, logic [31:0] now);
        int e;
        int b;
        e = shadow_free;
        if (e >= EMPTY_MARK)
            return 1'b0;
        shadow_free = shadow_link[e];
        shadow_link[e] = EMPTY_MARK;
        shadow_stamp[e] = now;
        shadow_addr[e] = addr;
        shadow_used++;
        b = bucket_index(addr);
        if (shadow_tail[b] < EMPTY_MARK)
            shadow_link[shadow_tail[b]] = e;
        else
            shadow_head[b] = e;
        shadow_tail[b] = e;
        return 1'b1;
    endfunction

    // Walk the bucket: drop stale entries, move a live match to the tail and refresh it.
    function automatic bit shadow_find(logic [31:0] addr, logic [31:0] now);
        int b;
        int prev;
        int e;
        int nx;
        int steps;
        bit can_age;
        logic [31:0] age;
        b = bucket_index(addr);
        can_age = shadow_interval <= now;
        age = now - shadow_interval;
        prev = EMPTY_MARK;
        e = shadow_head[b];
        steps = 0;
        while (e < EMPTY_MARK && steps < POOL_ENTRIES)
        begin
            nx = shadow_link[e];
            steps++;
            if (can_age && shadow_stamp[e] < age)
            begin
                if (prev < EMPTY_MARK)
                    shadow_link[prev] = nx;
                else
                    shadow_head[b] = nx;
                if (nx >= EMPTY_MARK)
                    shadow_tail[b] = prev;
                shadow_link[e] = shadow_free;
                shadow_free = e;
                if (shadow_used > 0)
                    shadow_used--;
                e = nx;
                continue;
            end
            if (shadow_addr[e] == addr)
            begin
                if (nx < EMPTY_MARK)
                begin
                    if (prev < EMPTY_MARK)
                        shadow_link[prev] = nx;
                    else
                        shadow_head[b] = nx;
                    shadow_link[e] = EMPTY_MARK;
                    if (shadow_tail[b] < EMPTY_MARK)
                        shadow_link[shadow_tail[b]] = e;
                    shadow_tail[b] = e;
                end
                shadow_stamp[e] = now;
                return 1'b1;
            end
            prev = e;
            e = nx;
        end
        return 1'b0;
    endfunction

    function automatic lookup_reply_t predict_reply(logic mode, logic [31:0] addr,
                                                    logic [31:0] now);
        lookup_reply_t r;
        r.success = (mode == MODE_FIND) ? shadow_find(addr, now) : shadow_add(addr, now);
        r.entries_used = 11'(shadow_used);
        return r;
    endfunction

    // Entered and left at a falling edge. Drive one beat, hold it until the
    // handshake; valid stays up afterwards until the next call or a drain drops it.
    // Ready depends only on registers, so it is read at the falling edge.
    // Directed rows carry a typed-in reply; others use the predictor.
    task automatic send_beat(logic mode, logic [31:0] addr, logic [31:0] now,
                             bit typed, lookup_reply_t typed_reply);
        int gap;
        lookup_reply_t r;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.mode         <= mode;
        in_ch.address      <= addr;
        in_ch.current_time <= now;
        while (!in_ch.ready)
            @(negedge clk);
        @(posedge clk);
        r = predict_reply(mode, addr, now);
        if (typed && r !== typed_reply)
        begin
            $error("directed row: typed %b/%0d disagrees with predictor %b/%0d",
                   typed_reply.success, typed_reply.entries_used,
                   r.success, r.entries_used);
            failed = 1'b1;
        end
        pending_replies.push_back(typed ? typed_reply : r);
        if (mode == MODE_ADD && r.success)
            known_addrs.push_back(addr);
        @(negedge clk);
    endtask

    // Drop valid, wait for every reply, then let a trailing walk finish before
    // a register write.
    task automatic drain_and_write(logic [31:0] value);
        int guard;
        guard = 0;
        in_ch.valid <= 1'b0;
        while (pending_replies.size() != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (40) @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        shadow_interval = value;
    endtask

    // Result side: random stall per beat, compare against the oldest expectation.
    // Fields are captured at the falling edge before the accepting edge.
    initial
    begin
        lookup_reply_t want;
        int stall;
        logic got_success;
        logic [10:0] got_used;
        out_ch.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (stall != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            while (!out_ch.valid)
                @(negedge clk);
            got_success = out_ch.success;
            got_used = out_ch.entries_used;
            @(posedge clk);
            if (pending_replies.size() == 0)
            begin
                $error("result beat with no expectation waiting");
                failed = 1'b1;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (got_success !== want.success)
                begin
                    $error("success: expected %b actual %b", want.success, got_success);
                    failed = 1'b1;
                end
                if (got_used !== want.entries_used)
                begin
                    $error("entries_used: expected %0d actual %0d",
                           want.entries_used, got_used);
                    failed = 1'b1;
                end
            end
            @(negedge clk);
        end
    end

    typedef struct {
        logic        mode;
        logic [31:0] addr;
        logic [31:0] now;
        bit          typed;
        logic        success;
        logic [10:0] used;
    } stim_row_t;

    initial
    begin
        stim_row_t rows[$];
        stim_row_t row;
        lookup_reply_t tr;
        logic [31:0] addr;
        logic [31:0] now;
        logic [31:0] clock_base;
        logic [31:0] phase_intervals[5];
        int guard;

        failed = 1'b0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.mode = MODE_ADD;
        in_ch.address = '0;
        in_ch.current_time = '0;
        reset_shadow();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table: empty finds, extreme addresses and times, refresh,
        // duplicates, expiry at the interval edge, age below zero.
        rows = '{
            '{MODE_FIND, 32'h0000_0000, 32'd0,          1'b1, 1'b0, 11'd0},
            '{MODE_ADD,  32'h0000_0000, 32'd0,          1'b1, 1'b1, 11'd1},
            '{MODE_ADD,  32'hFFFF_FFFF, 32'd0,          1'b1, 1'b1, 11'd2},
            '{MODE_FIND, 32'hFFFF_FFFF, 32'd10,         1'b1, 1'b1, 11'd2},
            '{MODE_FIND, 32'h0000_0000, 32'd59,         1'b1, 1'b1, 11'd2},
            '{MODE_ADD,  32'hA5A5_5A5A, 32'd100,        1'b1, 1'b1, 11'd3},
            '{MODE_ADD,  32'hA5A5_5A5A, 32'd100,        1'b1, 1'b1, 11'd4},
            '{MODE_FIND, 32'hA5A5_5A5A, 32'd120,        1'b0, 1'b0, 11'd0},
            '{MODE_FIND, 32'hA5A5_5A5A, 32'd180,        1'b0, 1'b0, 11'd0},
            '{MODE_FIND, 32'h0000_0000, 32'd200,        1'b0, 1'b0, 11'd0},
            '{MODE_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF,  1'b0, 1'b0, 11'd0},
            '{MODE_ADD,  32'h1234_5678, 32'hFFFF_FFFF,  1'b0, 1'b0, 11'd0},
            '{MODE_FIND, 32'h1234_5678, 32'hFFFF_FFFF,  1'b0, 1'b0, 11'd0},
            '{MODE_FIND, 32'h8765_4321, 32'd5,          1'b0, 1'b0, 11'd0}
        };
        foreach (rows[i])
        begin
            row = rows[i];
            tr.success = row.success;
            tr.entries_used = row.used;
            send_beat(row.mode, row.addr, row.now, row.typed, tr);
        end

        // Fill the pool past its end: the last adds must fail.
        drain_and_write(32'hFFFF_FFFF);
        for (int i = 0; i < POOL_ENTRIES + 4; i++)
            send_beat(MODE_ADD, $urandom, $urandom, 1'b0, tr);
        // Maximum interval never ages; a zero interval frees all older entries.
        for (int i = 0; i < 8; i++)
            send_beat(MODE_FIND, known_addrs[$urandom_range(0, known_addrs.size() - 1)],
                      32'hFFFF_FFFF, 1'b0, tr);
        drain_and_write(32'd0);
        for (int i = 0; i < 300; i++)
            send_beat(MODE_FIND, $urandom, 32'hFFFF_FFFF, 1'b0, tr);
        known_addrs.delete();

        // Random phases with a slowly advancing clock; small address set for
        // hits and duplicates, occasional wide values and time jumps.
        phase_intervals = '{32'd60, 32'd1, 32'd20, 32'd0, 32'hFFFF_FFFF};
        clock_base = 32'd50;
        foreach (phase_intervals[p])
        begin
            drain_and_write(phase_intervals[p]);
            for (int i = 0; i < RANDOM_ITEMS / 5; i++)
            begin
                clock_base += $urandom_range(0, 3);
                now = ($urandom_range(0, 19) == 0) ? $urandom : clock_base;
                if (known_addrs.size() != 0 && $urandom_range(0, 2) != 0)
                    addr = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
                else if ($urandom_range(0, 1) == 0)
                    addr = $urandom_range(0, 31);
                else
                    addr = $urandom;
                send_beat(($urandom_range(0, 1) == 1) ? MODE_FIND : MODE_ADD,
                          addr, now, 1'b0, tr);
                if (known_addrs.size() > 64)
                    void'(known_addrs.pop_front());
            end
        end

        // Drop valid, wait out every reply, then a trailing margin.
        in_ch.valid <= 1'b0;
        guard = 0;
        while (pending_replies.size() != 0 && guard < 500000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (40) @(negedge clk);
        if (pending_replies.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_replies.size());
            failed = 1'b1;
        end
        if (!failed)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
